// File: hw/rtl/aabb_collision_resolve_unit_assert.svh
// Assertion macros for the box collision resolve unit.
// Expects clk and rst_n in the scope of each use.
`ifndef AABB_COLLISION_RESOLVE_UNIT_ASSERT_SVH
`define AABB_COLLISION_RESOLVE_UNIT_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define ACR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle.
`define ACR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/acr_pkg.sv
// Shared widths, types and helper functions of the box collision resolve unit.
// No dependencies.
`default_nettype none

package acr_pkg;

  localparam int EDGE_W   = 20;          // Q12.8 edge coordinate
  localparam int SIZE_W   = 8;           // whole-pixel box size
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 8;
  localparam int EXT_W    = EDGE_W + 1;  // far edge = near edge + size
  localparam int SHIFT_W  = EXT_W + 1;   // difference of two far/near edges

  // Load enables of the register stages inside the axis slices.
  typedef struct packed {
    logic en2;
    logic en3;
  } acr_stage_en_t;

  // Far edge of a box: near edge plus the size scaled to Q.8.
  function automatic logic signed [EXT_W-1:0] acr_far_edge(
    input logic signed [EDGE_W-1:0] near_edge,
    input logic        [SIZE_W-1:0] size
  );
    logic signed [EXT_W-1:0] near_x;
    logic signed [EXT_W-1:0] size_x;
    near_x = EXT_W'(near_edge);
    size_x = $signed({{(EXT_W - SIZE_W - FRAC_W){1'b0}}, size, {FRAC_W{1'b0}}});
    return near_x + size_x;
  endfunction

  // Magnitude of a signed overlap.
  function automatic logic [SHIFT_W-1:0] acr_mag(input logic signed [SHIFT_W-1:0] v);
    logic signed [SHIFT_W-1:0] neg;
    neg = -v;
    return v[SHIFT_W-1] ? SHIFT_W'(neg) : SHIFT_W'(v);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/acr_in_if.sv
// Input channel of the box collision resolve unit: one box pair per beat.
// Depends on acr_pkg.
`default_nettype none

interface acr_in_if import acr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [EDGE_W-1:0]   left_a;
  logic signed [EDGE_W-1:0]   top_a;
  logic        [SIZE_W-1:0]   width_a;
  logic        [SIZE_W-1:0]   height_a;
  logic        [WEIGHT_W-1:0] weight_a;
  logic signed [EDGE_W-1:0]   left_b;
  logic signed [EDGE_W-1:0]   top_b;
  logic        [SIZE_W-1:0]   width_b;
  logic        [SIZE_W-1:0]   height_b;
  logic        [WEIGHT_W-1:0] weight_b;

  modport source (
    output valid, left_a, top_a, width_a, height_a, weight_a,
           left_b, top_b, width_b, height_b, weight_b,
    input  ready
  );

  modport sink (
    input  valid, left_a, top_a, width_a, height_a, weight_a,
           left_b, top_b, width_b, height_b, weight_b,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/acr_out_if.sv
// Result channel of the box collision resolve unit: one resolution per beat.
// Depends on acr_pkg.
`default_nettype none

interface acr_out_if import acr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic                      moved_box;
  logic signed [SHIFT_W-1:0] shift_x;
  logic signed [SHIFT_W-1:0] shift_y;
  logic                      clear_vel_x;
  logic                      clear_vel_y;

  modport source (
    output valid, hit, moved_box, shift_x, shift_y, clear_vel_x, clear_vel_y,
    input  ready
  );

  modport sink (
    input  valid, hit, moved_box, shift_x, shift_y, clear_vel_x, clear_vel_y,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/acr_axis.sv
// One axis of the resolve pipeline: span test, both signed overlaps, pick.
// Depends on acr_pkg; stage enables come from the top level.
`default_nettype none

module acr_axis import acr_pkg::*; (
  input  wire logic                      clk,
  input  wire acr_stage_en_t             en,
  input  wire logic                      moved_b,   // 1: box B moves
  input  wire logic signed [EXT_W-1:0]   lo_a,
  input  wire logic signed [EXT_W-1:0]   hi_a,
  input  wire logic signed [EXT_W-1:0]   lo_b,
  input  wire logic signed [EXT_W-1:0]   hi_b,
  output logic                           hit,
  output logic signed [SHIFT_W-1:0]      ov,
  output logic        [SHIFT_W-1:0]      ov_mag
);

  logic signed [EXT_W-1:0]   lo_f, hi_f, lo_m, hi_m;
  logic signed [SHIFT_W-1:0] d_far_nxt, d_near_nxt;
  logic                      hit_nxt;
  logic signed [SHIFT_W-1:0] d_far_r, d_near_r;
  logic                      hit2_r;
  logic [SHIFT_W-1:0]        mag_far, mag_near;
  logic signed [SHIFT_W-1:0] ov_nxt;
  logic signed [SHIFT_W-1:0] ov_r;
  logic [SHIFT_W-1:0]        ov_mag_r;
  logic                      hit3_r;

  // Stage 2: split into fixed and moving spans, form both overlaps.
  always_comb begin
    lo_f = moved_b ? lo_a : lo_b;
    hi_f = moved_b ? hi_a : hi_b;
    lo_m = moved_b ? lo_b : lo_a;
    hi_m = moved_b ? hi_b : hi_a;
    d_far_nxt  = SHIFT_W'(hi_f) - SHIFT_W'(lo_m);
    d_near_nxt = SHIFT_W'(lo_f) - SHIFT_W'(hi_m);
    // touching edges count as a hit
    hit_nxt = !((hi_a < lo_b) || (lo_a > hi_b));
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      d_far_r  <= d_far_nxt;
      d_near_r <= d_near_nxt;
      hit2_r   <= hit_nxt;
    end
  end

  // Stage 3: keep the smaller overlap, the far one on a tie.
  always_comb begin
    mag_far  = acr_mag(d_far_r);
    mag_near = acr_mag(d_near_r);
    ov_nxt   = (mag_far <= mag_near) ? d_far_r : d_near_r;
  end

  always_ff @(posedge clk) begin
    if (en.en3) begin
      ov_r     <= ov_nxt;
      ov_mag_r <= (mag_far <= mag_near) ? mag_far : mag_near;
      hit3_r   <= hit2_r;
    end
  end

  assign hit    = hit3_r;
  assign ov     = ov_r;
  assign ov_mag = ov_mag_r;

endmodule

`default_nettype wire

// File: hw/rtl/aabb_collision_resolve_unit.sv
// Top level of the box collision resolve unit: four-stage pipeline.
// Depends on acr_pkg, acr_in_if, acr_out_if, acr_axis and the assert macro header.
//
// Usage:
//   in_ch carries one box pair per beat (edges Q12.8, sizes in pixels, weights).
//   out_ch returns exactly one beat per input beat, in order: hit flag, which box
//   moves (the lighter one, box B on equal weight), the Q.8 shift for the moved
//   box and flags for the velocity components to clear. With no hit every
//   result field is zero.
//   Path: an accepted beat is registered after each step in order: edge extension
//   and weight compare, overlaps, per-axis pick, axis choice into the output
//   register, from which out_ch offers it.
//   Throughput: one beat per cycle sustained while out_ch.ready stays high; four
//   register stages each hold a valid bit, and every stage takes a new beat
//   whenever it is empty or the stage after it advances.
//   Stall: while out_ch.ready is low the output register holds its beat; the
//   stall ripples back stage by stage, empty stages still fill, and in_ch.ready
//   drops only when every stage is occupied. Nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; in_ch.ready is high
//   right after reset.
`default_nettype none

module aabb_collision_resolve_unit import acr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  acr_in_if.sink     in_ch,
  acr_out_if.source  out_ch
);

  // Stage valid bits and load enables.
  logic          v1_r, v2_r, v3_r, v4_r;
  logic          en1, en4;
  acr_stage_en_t en;

  // Advance a stage when it is empty or its successor advances.
  assign en4    = !v4_r || out_ch.ready;
  assign en.en3 = !v3_r || en4;
  assign en.en2 = !v2_r || en.en3;
  assign en1    = !v1_r || en.en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1)    v1_r <= in_ch.valid;
      if (en.en2) v2_r <= v1_r;
      if (en.en3) v3_r <= v2_r;
      if (en4)    v4_r <= v3_r;
    end
  end

  // Stage 1: extend edges to far edges, decide which box moves.
  logic signed [EXT_W-1:0] la1_r, ra1_r, ta1_r, ba1_r;
  logic signed [EXT_W-1:0] lb1_r, rb1_r, tb1_r, bb1_r;
  logic                    mv1_r;
  logic                    mv_nxt;

  // Strictly lighter A moves; otherwise B moves.
  assign mv_nxt = !(in_ch.weight_a < in_ch.weight_b);

  always_ff @(posedge clk) begin
    if (en1) begin
      la1_r <= EXT_W'(in_ch.left_a);
      ta1_r <= EXT_W'(in_ch.top_a);
      ra1_r <= acr_far_edge(in_ch.left_a, in_ch.width_a);
      ba1_r <= acr_far_edge(in_ch.top_a, in_ch.height_a);
      lb1_r <= EXT_W'(in_ch.left_b);
      tb1_r <= EXT_W'(in_ch.top_b);
      rb1_r <= acr_far_edge(in_ch.left_b, in_ch.width_b);
      bb1_r <= acr_far_edge(in_ch.top_b, in_ch.height_b);
      mv1_r <= mv_nxt;
    end
  end

  // Stages 2 and 3: per-axis span test and overlap pick.
  logic                      hit_x, hit_y;
  logic signed [SHIFT_W-1:0] ov_x, ov_y;
  logic [SHIFT_W-1:0]        mag_x, mag_y;
  logic                      mv2_r, mv3_r;

  acr_axis u_axis_x (
    .clk     (clk),
    .en      (en),
    .moved_b (mv1_r),
    .lo_a    (la1_r),
    .hi_a    (ra1_r),
    .lo_b    (lb1_r),
    .hi_b    (rb1_r),
    .hit     (hit_x),
    .ov      (ov_x),
    .ov_mag  (mag_x)
  );

  acr_axis u_axis_y (
    .clk     (clk),
    .en      (en),
    .moved_b (mv1_r),
    .lo_a    (ta1_r),
    .hi_a    (ba1_r),
    .lo_b    (tb1_r),
    .hi_b    (bb1_r),
    .hit     (hit_y),
    .ov      (ov_y),
    .ov_mag  (mag_y)
  );

  // Carry the mover choice alongside the axis slices.
  always_ff @(posedge clk) begin
    if (en.en2) mv2_r <= mv1_r;
    if (en.en3) mv3_r <= mv2_r;
  end

  // Stage 4: choose the axis of smaller overlap (both on a tie), zero on miss.
  logic                      hit_nxt, moved_nxt, cx_nxt, cy_nxt;
  logic signed [SHIFT_W-1:0] sx_nxt, sy_nxt;
  logic                      hit_r, moved_r, cx_r, cy_r;
  logic signed [SHIFT_W-1:0] sx_r, sy_r;

  always_comb begin
    hit_nxt   = hit_x && hit_y;
    moved_nxt = hit_nxt && mv3_r;
    cx_nxt    = hit_nxt && (mag_x <= mag_y);
    cy_nxt    = hit_nxt && (mag_y <= mag_x);
    sx_nxt    = cx_nxt ? ov_x : '0;
    sy_nxt    = cy_nxt ? ov_y : '0;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      hit_r   <= hit_nxt;
      moved_r <= moved_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
    end
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.moved_box   = moved_r;
  assign out_ch.shift_x     = sx_r;
  assign out_ch.shift_y     = sy_r;
  assign out_ch.clear_vel_x = cx_r;
  assign out_ch.clear_vel_y = cy_r;

  // Checks on the result beat.
`include "aabb_collision_resolve_unit_assert.svh"

  // A miss carries no mover, shift or clear flag.
  `ACR_ASSERT_IMPL(a_miss_is_zero, out_ch.valid && !out_ch.hit, !out_ch.moved_box && (out_ch.shift_x == '0) && (out_ch.shift_y == '0) && !out_ch.clear_vel_x && !out_ch.clear_vel_y, "miss beat carries nonzero resolution")
  // A hit always resolves along at least one axis.
  `ACR_ASSERT_IMPL(a_hit_has_axis, out_ch.valid && out_ch.hit, out_ch.clear_vel_x || out_ch.clear_vel_y, "hit beat resolves along no axis")
  // A shift only appears on an axis whose velocity is cleared.
  `ACR_ASSERT_ALWAYS(a_shift_needs_clear, !out_ch.valid || ((out_ch.clear_vel_x || (out_ch.shift_x == '0)) && (out_ch.clear_vel_y || (out_ch.shift_y == '0))), "shift on an axis that was not chosen")

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for aabb_collision_resolve_unit: random and directed box pairs,
// predicted overlap resolution checked beat by beat against the result channel.
// Depends on acr_pkg, acr_in_if, acr_out_if and the unit itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import acr_pkg::*;

  localparam int RANDOM_PAIRS = 1830;
  localparam int QUIET_TAIL   = 150;     // beats at the end with no idling at all
  localparam int HOLD_AT_BEAT = 500;     // where the long receiver stall starts
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;       // pipeline is four stages deep
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic signed [EDGE_W-1:0]   left_a;
    logic signed [EDGE_W-1:0]   top_a;
    logic        [SIZE_W-1:0]   width_a;
    logic        [SIZE_W-1:0]   height_a;
    logic        [WEIGHT_W-1:0] weight_a;
    logic signed [EDGE_W-1:0]   left_b;
    logic signed [EDGE_W-1:0]   top_b;
    logic        [SIZE_W-1:0]   width_b;
    logic        [SIZE_W-1:0]   height_b;
    logic        [WEIGHT_W-1:0] weight_b;
  } box_pair_t;

  typedef struct packed {
    logic                      hit;
    logic                      moved_box;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic                      clear_vel_x;
    logic                      clear_vel_y;
  } resolution_t;

  logic clk = 1'b0;
  logic rst_n;

  acr_in_if  in_ch ();
  acr_out_if out_ch ();

  aabb_collision_resolve_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  box_pair_t   pending_pairs[$];      // pairs waiting to be offered, oldest first
  resolution_t expected_resolutions[$];

  int beats_in    = 0;
  int beats_out   = 0;
  int errors      = 0;
  int cycle_count = 0;
  int send_gap    = 0;
  int recv_gap    = 0;
  int hold_left   = 0;
  int tail_start  = 32'h7fffffff;
  bit hold_done   = 1'b0;
  bit pair_taken  = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pick the overlap of smaller magnitude; the first one wins a tie.
  function automatic int smaller_overlap(input int first, input int second);
    int mag_first;
    int mag_second;
    mag_first  = (first < 0) ? -first : first;
    mag_second = (second < 0) ? -second : second;
    return (mag_first <= mag_second) ? first : second;
  endfunction

  // Predict the resolution of one box pair.
  function automatic resolution_t resolve_pair(input box_pair_t p);
    resolution_t r;
    int la, ta, ra, ba, lb, tb, rb, bb;
    int lf, rf, tf, bf, lm, rm, tm, bm;
    int ox, oy, mag_x, mag_y;
    r  = '0;
    la = $signed(p.left_a);
    ta = $signed(p.top_a);
    lb = $signed(p.left_b);
    tb = $signed(p.top_b);
    // Sizes are whole pixels: scale them into Q.8 before adding.
    ra = la + (int'(p.width_a) << FRAC_W);
    ba = ta + (int'(p.height_a) << FRAC_W);
    rb = lb + (int'(p.width_b) << FRAC_W);
    bb = tb + (int'(p.height_b) << FRAC_W);
    // Touching edges still count as a hit.
    r.hit = !(ra < lb || la > rb || ba < tb || ta > bb);
    if (r.hit) begin
      // Move the lighter box; on equal weight box B moves.
      if (p.weight_a < p.weight_b) begin
        r.moved_box = 1'b0;
        lf = lb; rf = rb; tf = tb; bf = bb;
        lm = la; rm = ra; tm = ta; bm = ba;
      end else begin
        r.moved_box = 1'b1;
        lf = la; rf = ra; tf = ta; bf = ba;
        lm = lb; rm = rb; tm = tb; bm = bb;
      end
      ox    = smaller_overlap(rf - lm, lf - rm);
      oy    = smaller_overlap(bf - tm, tf - bm);
      mag_x = (ox < 0) ? -ox : ox;
      mag_y = (oy < 0) ? -oy : oy;
      // Shift along the shallower axis, or along both on a tie.
      if (mag_x <= mag_y) begin
        r.shift_x     = SHIFT_W'(ox);
        r.clear_vel_x = 1'b1;
      end
      if (mag_y <= mag_x) begin
        r.shift_y     = SHIFT_W'(oy);
        r.clear_vel_y = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic add_pair(input int la, input int ta, input int wa, input int ha, input int ga,
                          input int lb, input int tb, input int wb, input int hb, input int gb);
    box_pair_t p;
    p.left_a   = EDGE_W'(la);
    p.top_a    = EDGE_W'(ta);
    p.width_a  = SIZE_W'(wa);
    p.height_a = SIZE_W'(ha);
    p.weight_a = WEIGHT_W'(ga);
    p.left_b   = EDGE_W'(lb);
    p.top_b    = EDGE_W'(tb);
    p.width_b  = SIZE_W'(wb);
    p.height_b = SIZE_W'(hb);
    p.weight_b = WEIGHT_W'(gb);
    pending_pairs.push_back(p);
  endtask

  // Mostly pairs placed close together so that hits, touches and ties are
  // common; the rest is raw noise over the full field ranges.
  function automatic box_pair_t random_pair();
    box_pair_t p;
    int la, ta, dx, dy, reach_a, reach_b;
    p.left_a   = EDGE_W'($urandom);
    p.top_a    = EDGE_W'($urandom);
    p.width_a  = SIZE_W'($urandom);
    p.height_a = SIZE_W'($urandom);
    p.weight_a = WEIGHT_W'($urandom);
    p.left_b   = EDGE_W'($urandom);
    p.top_b    = EDGE_W'($urandom);
    p.width_b  = SIZE_W'($urandom);
    p.height_b = SIZE_W'($urandom);
    p.weight_b = WEIGHT_W'($urandom);
    if ($urandom_range(0, 9) < 3)
      return p;
    // Tiny boxes now and then, down to zero size.
    if ($urandom_range(0, 5) == 0) begin
      p.width_a  = SIZE_W'($urandom_range(0, 3));
      p.height_a = SIZE_W'($urandom_range(0, 3));
      p.width_b  = SIZE_W'($urandom_range(0, 3));
      p.height_b = SIZE_W'($urandom_range(0, 3));
    end
    // Keep box A clear of the rails so that B's edges stay in range.
    la      = int'($urandom_range(0, 900000)) - 450000;
    ta      = int'($urandom_range(0, 900000)) - 450000;
    reach_a = int'(p.width_a) << FRAC_W;
    reach_b = int'(p.width_b) << FRAC_W;
    dx      = int'($urandom_range(0, reach_a + reach_b + 512)) - reach_b - 256;
    reach_a = int'(p.height_a) << FRAC_W;
    reach_b = int'(p.height_b) << FRAC_W;
    dy      = int'($urandom_range(0, reach_a + reach_b + 512)) - reach_b - 256;
    case ($urandom_range(0, 7))
      0: dx = int'(p.width_a) << FRAC_W;        // B's left edge on A's right edge
      1: dy = -(int'(p.height_b) << FRAC_W);    // B's bottom edge on A's top edge
      2: begin                                  // square-ish diagonal: both axes tie
        p.height_a = p.width_a;
        p.height_b = p.width_b;
        dy         = dx;
      end
      default: ;
    endcase
    p.left_a = EDGE_W'(la);
    p.top_a  = EDGE_W'(ta);
    p.left_b = EDGE_W'(la + dx);
    p.top_b  = EDGE_W'(ta + dy);
    case ($urandom_range(0, 3))
      0: p.weight_b = p.weight_a;
      1: p.weight_b = p.weight_a + 1'b1;
      default: ;
    endcase
    return p;
  endfunction

  // Idle only outside the quiet windows and never in the closing stretch.
  function automatic bit idling_allowed();
    return (beats_in < tail_start) && ((beats_in / 150) % 4 != 3);
  endfunction

  task automatic compare_field(input string name, input logic signed [SHIFT_W-1:0] want,
                               input logic signed [SHIFT_W-1:0] seen);
    if (seen !== want) begin
      errors++;
      if (errors <= 10)
        $display("mismatch in %s at result beat %0d: expected %0d, got %0d",
                 name, beats_out, want, seen);
    end
  endtask

  // Driver: present the oldest pending pair at the falling edge. Hold a beat
  // that was offered but not taken; otherwise insert idle bursts at random.
  always @(negedge clk) begin : driver
    logic offer;
    if (!rst_n) begin
      offer = 1'b0;
    end else if (in_ch.valid && !pair_taken) begin
      offer = 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      offer = 1'b0;
    end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
      send_gap = $urandom_range(0, 12);
      offer    = 1'b0;
    end else begin
      offer = (pending_pairs.size() != 0);
    end
    in_ch.valid <= offer;
    if (offer) begin
      in_ch.left_a   <= pending_pairs[0].left_a;
      in_ch.top_a    <= pending_pairs[0].top_a;
      in_ch.width_a  <= pending_pairs[0].width_a;
      in_ch.height_a <= pending_pairs[0].height_a;
      in_ch.weight_a <= pending_pairs[0].weight_a;
      in_ch.left_b   <= pending_pairs[0].left_b;
      in_ch.top_b    <= pending_pairs[0].top_b;
      in_ch.width_b  <= pending_pairs[0].width_b;
      in_ch.height_b <= pending_pairs[0].height_b;
      in_ch.weight_b <= pending_pairs[0].weight_b;
    end
  end

  // Receiver: drop ready in random bursts, and once stall for a long stretch
  // while the driver keeps offering, so the pipeline fills and backs up.
  always @(negedge clk) begin : receiver
    logic take;
    if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      take = 1'b0;
    end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 12);
      take     = 1'b0;
    end else begin
      take = 1'b1;
    end
    out_ch.ready <= take;
  end

  // Monitor: on each rising edge record accepted pairs with their predicted
  // resolution and check each accepted result against the oldest prediction.
  always @(posedge clk) begin : monitor
    resolution_t want;
    resolution_t seen;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end else begin
      pair_taken = rst_n && in_ch.valid && in_ch.ready;
      if (pair_taken) begin
        expected_resolutions.push_back(resolve_pair(pending_pairs[0]));
        void'(pending_pairs.pop_front());
        beats_in++;
      end
      if (rst_n && out_ch.valid && out_ch.ready) begin
        seen.hit         = out_ch.hit;
        seen.moved_box   = out_ch.moved_box;
        seen.shift_x     = out_ch.shift_x;
        seen.shift_y     = out_ch.shift_y;
        seen.clear_vel_x = out_ch.clear_vel_x;
        seen.clear_vel_y = out_ch.clear_vel_y;
        if (expected_resolutions.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result beat %0d arrived with nothing expected", beats_out);
        end else begin
          want = expected_resolutions.pop_front();
          compare_field("hit", want.hit, seen.hit);
          compare_field("moved_box", want.moved_box, seen.moved_box);
          compare_field("shift_x", want.shift_x, seen.shift_x);
          compare_field("shift_y", want.shift_y, seen.shift_y);
          compare_field("clear_vel_x", want.clear_vel_x, seen.clear_vel_x);
          compare_field("clear_vel_y", want.clear_vel_y, seen.clear_vel_y);
        end
        beats_out++;
      end
    end
  end

  // Stimulus: reset, a directed set, a full drain with the sender paused,
  // then the random pairs and the final drain.
  initial begin : stimulus
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.left_a   = '0;
    in_ch.top_a    = '0;
    in_ch.width_a  = '0;
    in_ch.height_a = '0;
    in_ch.weight_a = '0;
    in_ch.left_b   = '0;
    in_ch.top_b    = '0;
    in_ch.width_b  = '0;
    in_ch.height_b = '0;
    in_ch.weight_b = '0;
    out_ch.ready   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Degenerate: two zero-size boxes at the origin touch as points.
    add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Clear gap along x, then touching edges, then one fraction bit apart.
    add_pair(0, 0, 4, 4, 10, 2048, 0, 4, 4, 20);
    add_pair(0, 0, 4, 4, 10, 1024, 0, 4, 4, 20);
    add_pair(0, 0, 4, 4, 10, 1025, 0, 4, 4, 20);
    // Along y: one fraction bit apart with equal weights, then touching with box B lighter.
    add_pair(0, 0, 4, 4, 5, 0, 1025, 4, 4, 5);
    add_pair(0, 0, 4, 4, 9, 0, 1024, 4, 4, 3);
    // Shallow along x only, then shallow along y only.
    add_pair(0, 0, 8, 8, 100, 1792, 256, 4, 4, 50);
    add_pair(0, 0, 8, 8, 50, 256, 1792, 4, 4, 100);
    // Moved box centered in the fixed one: both overlaps of an axis tie.
    add_pair(0, 0, 4, 4, 7, 256, 256, 2, 2, 7);
    // Corner overlap, equal depth on both axes.
    add_pair(0, 0, 4, 4, 1, 768, 768, 4, 4, 1);
    // Overlap from the negative side: the x shift comes out negative.
    add_pair(0, 0, 4, 4, 7, -256, -128, 2, 8, 7);
    // Zero-size box inside a bigger one.
    add_pair(0, 0, 0, 0, 3, -512, -512, 8, 8, 4);
    // Opposite rails, no hit; then both boxes at each rail with largest sizes.
    add_pair(-524288, -524288, 255, 255, 0, 524287, 524287, 255, 255, 65535);
    add_pair(524287, 524287, 255, 255, 65535, 524287, 524287, 255, 255, 65535);
    add_pair(-524288, -524288, 255, 255, 0, -524288, -524288, 255, 255, 0);
    // Overlaps of the largest boxes; the first is deep on both axes.
    add_pair(-524288, 0, 255, 255, 1, -524160, 128, 255, 255, 2);
    add_pair(524287, -524288, 255, 255, 65535, 524287 - 65000, -524288 + 300, 255, 255, 0);
    // Fractional negative coordinates and edges crossing zero.
    add_pair(-1, -1, 1, 1, 2, -257, -1, 1, 1, 2);
    add_pair(-300, 100, 3, 1, 65535, 200, -200, 2, 2, 65534);
    // All-ones fields.
    add_pair(-1, -1, 255, 255, 65535, -1, -1, 255, 255, 65535);
    // Weight extremes, box A at zero so A moves.
    add_pair(0, 0, 2, 2, 0, 128, 256, 2, 2, 65535);

    // Pause the sender until every directed result is back.
    while (pending_pairs.size() != 0 || expected_resolutions.size() != 0)
      @(posedge clk);

    tail_start = beats_in + RANDOM_PAIRS - QUIET_TAIL;
    for (int i = 0; i < RANDOM_PAIRS; i++)
      pending_pairs.push_back(random_pair());

    while (pending_pairs.size() != 0 || expected_resolutions.size() != 0)
      @(posedge clk);
    // Catch any stray beat after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
